// File: rtl/core/murmur3_128_stream_hash_unit_macros.svh
// Assertion helpers shared by the hash unit RTL.
// Both macros expect clk and rst_n in the scope where they are used.
`ifndef MURMUR3_128_STREAM_HASH_UNIT_MACROS_SVH
`define MURMUR3_128_STREAM_HASH_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MM3_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MM3_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/mm3_pkg.sv
package mm3_pkg;

  // Mixing constants of the 64-bit, 128-bit output variant.
  localparam logic [63:0] C1   = 64'h87c3_7b91_1142_53d5;
  localparam logic [63:0] C2   = 64'h4cf5_ad43_2745_937f;
  localparam logic [63:0] FM1  = 64'hff51_afd7_ed55_8ccd;
  localparam logic [63:0] FM2  = 64'hc4ce_b9fe_1a85_ec53;
  localparam logic [63:0] ADD1 = 64'h0000_0000_52dc_e729;
  localparam logic [63:0] ADD2 = 64'h0000_0000_3849_5ab5;

  // Bytes in one full chunk.
  localparam logic [4:0] CHUNK_BYTES = 5'd16;

  // Default depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH_DEF = 2;

  // One classified chunk as the back end consumes it.
  typedef struct packed {
    logic [63:0] lo;       // bytes 0 to 7, unused bytes zeroed
    logic [63:0] hi;       // bytes 8 to 15, unused bytes zeroed
    logic [4:0]  add_len;  // bytes this chunk adds to the message length
    logic        full;     // mix as a full block
    logic        last;     // finish the hash after this chunk
  } entry_t;

endpackage

// File: rtl/core/mm3_front.sv
module mm3_front (
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [63:0]      in_block_low,
  input  logic [63:0]      in_block_high,
  input  logic [4:0]       in_byte_count,
  input  logic             in_last_block,
  input  logic             q_full,
  output logic             q_push,
  output mm3_pkg::entry_t  q_entry
);
  import mm3_pkg::*;

  logic        full;
  logic [4:0]  cnt_sat;
  logic [63:0] lo_mask;
  logic [63:0] hi_mask;

  // A non-last chunk, or a last one with sixteen or more bytes, is a full block.
  // Otherwise only the first cnt_sat bytes survive; the rest read as zero.
  always_comb begin
    full    = !in_last_block || (in_byte_count >= CHUNK_BYTES);
    cnt_sat = full ? CHUNK_BYTES : in_byte_count;
    for (int i = 0; i < 8; i++) begin
      lo_mask[8*i +: 8] = (cnt_sat > 5'(i))     ? 8'hff : 8'h00;
      hi_mask[8*i +: 8] = (cnt_sat > 5'(i + 8)) ? 8'hff : 8'h00;
    end
  end

  // An item is taken whenever the queue has room.
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  assign q_entry = '{
    lo:      in_block_low & lo_mask,
    hi:      in_block_high & hi_mask,
    add_len: cnt_sat,
    full:    full,
    last:    in_last_block
  };

endmodule

// File: rtl/core/mm3_queue.sv
module mm3_queue #(
  parameter int DEPTH = mm3_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  mm3_pkg::entry_t  push_entry,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output mm3_pkg::entry_t  head
);
  import mm3_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t          slot_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = slot_r[rd_ptr_r];

  // Pointers wrap at the depth; the count tracks occupancy.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Slot storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// File: rtl/core/mm3_mul64.sv
module mm3_mul64 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] product
);

  // Low 64 bits of a*b from three 32x32 partial products, one per cycle:
  // lo*lo, then lo(a)*hi(b), then hi(a)*lo(b), the cross terms shifted up 32.
  localparam logic [1:0] STEP_LL = 2'd0;
  localparam logic [1:0] STEP_LH = 2'd1;
  localparam logic [1:0] STEP_HL = 2'd2;

  logic [1:0]  step_r, step_nxt;
  logic [63:0] acc_r;
  logic [31:0] op_a, op_b;
  logic [63:0] part;
  logic [63:0] sum;

  always_comb begin
    op_a = (step_r == STEP_HL) ? a[63:32] : a[31:0];
    op_b = (step_r == STEP_LH) ? b[63:32] : b[31:0];
    part = op_a * op_b;
    sum  = acc_r + {part[31:0], 32'h0};
  end

  assign done    = go && (step_r == STEP_HL);
  assign product = sum;

  // The step counter runs only while a product is requested.
  always_comb begin
    step_nxt = STEP_LL;
    if (go) begin
      case (step_r)
        STEP_LL: step_nxt = STEP_LH;
        STEP_LH: step_nxt = STEP_HL;
        default: step_nxt = STEP_LL;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_LL;
    end else begin
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= (step_r == STEP_LL) ? part : sum;
  end

endmodule

// File: rtl/core/mm3_back.sv
`include "murmur3_128_stream_hash_unit_macros.svh"

module mm3_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  output logic             q_pop,
  input  mm3_pkg::entry_t  q_head,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [63:0]      out_hash_value
);
  import mm3_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE = 15'b000_0000_0000_0001,
    S_K1A  = 15'b000_0000_0000_0010,
    S_K1B  = 15'b000_0000_0000_0100,
    S_L1A  = 15'b000_0000_0000_1000,
    S_L1B  = 15'b000_0000_0001_0000,
    S_K2A  = 15'b000_0000_0010_0000,
    S_K2B  = 15'b000_0000_0100_0000,
    S_L2A  = 15'b000_0000_1000_0000,
    S_L2B  = 15'b000_0001_0000_0000,
    S_FOLD = 15'b000_0010_0000_0000,
    S_F1A  = 15'b000_0100_0000_0000,
    S_F1B  = 15'b000_1000_0000_0000,
    S_F2A  = 15'b001_0000_0000_0000,
    S_F2B  = 15'b010_0000_0000_0000,
    S_OUT  = 15'b100_0000_0000_0000
  } state_t;

  function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned r);
    return (x << r) | (x >> (64 - r));
  endfunction

  function automatic logic [63:0] xsh33(input logic [63:0] x);
    return x ^ (x >> 33);
  endfunction

  state_t      state_r, state_nxt;
  entry_t      ent_r, ent_nxt;
  logic [63:0] h1_r, h1_nxt;
  logic [63:0] h2_r, h2_nxt;
  logic [63:0] len_r, len_nxt;
  logic [63:0] k_r, k_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_hash_r, out_hash_nxt;
  logic        out_load;

  logic        mul_go;
  logic [63:0] mul_a, mul_b;
  logic        mul_done;
  logic [63:0] mul_p;

  mm3_mul64 u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (mul_go),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_p)
  );

  // Sequencer: scramble both halves, update the lanes, and on the last item
  // fold in the length, run both finalizers and hand out the sum.
  always_comb begin
    state_nxt     = state_r;
    ent_nxt       = ent_r;
    h1_nxt        = h1_r;
    h2_nxt        = h2_r;
    len_nxt       = len_r;
    k_nxt         = k_r;
    out_hash_nxt  = out_hash_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_load      = 1'b0;
    q_pop         = 1'b0;
    mul_go        = 1'b0;
    mul_a         = '0;
    mul_b         = '0;

    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          ent_nxt   = q_head;
          state_nxt = S_K1A;
        end
      end
      S_K1A: begin
        mul_go = 1'b1;
        mul_a  = ent_r.lo;
        mul_b  = C1;
        if (mul_done) begin
          k_nxt     = rotl(mul_p, 31);
          len_nxt   = len_r + 64'(ent_r.add_len);
          state_nxt = S_K1B;
        end
      end
      S_K1B: begin
        mul_go = 1'b1;
        mul_a  = k_r;
        mul_b  = C2;
        if (mul_done) begin
          h1_nxt    = h1_r ^ mul_p;
          state_nxt = ent_r.full ? S_L1A : S_K2A;
        end
      end
      S_L1A: begin
        h1_nxt    = rotl(h1_r, 27) + h2_r;
        state_nxt = S_L1B;
      end
      S_L1B: begin
        h1_nxt    = (h1_r << 2) + h1_r + ADD1;
        state_nxt = S_K2A;
      end
      S_K2A: begin
        mul_go = 1'b1;
        mul_a  = ent_r.hi;
        mul_b  = C2;
        if (mul_done) begin
          k_nxt     = rotl(mul_p, 33);
          state_nxt = S_K2B;
        end
      end
      S_K2B: begin
        mul_go = 1'b1;
        mul_a  = k_r;
        mul_b  = C1;
        if (mul_done) begin
          h2_nxt = h2_r ^ mul_p;
          if (ent_r.full) begin
            state_nxt = S_L2A;
          end else begin
            state_nxt = ent_r.last ? S_FOLD : S_IDLE;
          end
        end
      end
      S_L2A: begin
        h2_nxt    = rotl(h2_r, 31) + h1_r;
        state_nxt = S_L2B;
      end
      S_L2B: begin
        h2_nxt    = (h2_r << 2) + h2_r + ADD2;
        state_nxt = ent_r.last ? S_FOLD : S_IDLE;
      end
      S_FOLD: begin
        h1_nxt    = (h1_r ^ len_r) + (h2_r ^ len_r);
        h2_nxt    = h2_r ^ len_r;
        state_nxt = S_F1A;
      end
      S_F1A: begin
        mul_go = 1'b1;
        mul_a  = xsh33(h1_r);
        mul_b  = FM1;
        if (mul_done) begin
          // The lane-two half of the fold uses the folded lane one.
          h2_nxt    = h2_r + h1_r;
          k_nxt     = xsh33(mul_p);
          state_nxt = S_F1B;
        end
      end
      S_F1B: begin
        mul_go = 1'b1;
        mul_a  = k_r;
        mul_b  = FM2;
        if (mul_done) begin
          h1_nxt    = xsh33(mul_p);
          state_nxt = S_F2A;
        end
      end
      S_F2A: begin
        mul_go = 1'b1;
        mul_a  = xsh33(h2_r);
        mul_b  = FM1;
        if (mul_done) begin
          k_nxt     = xsh33(mul_p);
          state_nxt = S_F2B;
        end
      end
      S_F2B: begin
        mul_go = 1'b1;
        mul_a  = k_r;
        mul_b  = FM2;
        if (mul_done) begin
          h2_nxt    = xsh33(mul_p);
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // Wait for the output register, then clear the lanes for a new message.
        if (!out_valid_r || out_ready) begin
          out_load      = 1'b1;
          out_hash_nxt  = h1_r + h2_r;
          out_valid_nxt = 1'b1;
          h1_nxt        = '0;
          h2_nxt        = '0;
          len_nxt       = '0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      h1_r        <= '0;
      h2_r        <= '0;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      h1_r        <= h1_nxt;
      h2_r        <= h2_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working copies need no reset.
  always_ff @(posedge clk) begin
    ent_r      <= ent_nxt;
    k_r        <= k_nxt;
    out_hash_r <= out_hash_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;

  `MM3_ASSERT_NOW(a_state_onehot, 1'b1, $onehot(state_r), "Sequencer state is not one-hot.")
  `MM3_ASSERT_NEXT(a_lanes_cleared, (state_r == S_OUT) && out_load,
    (h1_r == '0) && (h2_r == '0) && (len_r == '0), "Lanes not cleared after a result.")
  `MM3_ASSERT_NOW(a_result_from_finish, $rose(out_valid_r), $past(state_r) == S_OUT,
    "Result raised outside the finish step.")
  `MM3_ASSERT_NEXT(a_length_step, (state_r == S_K1A) && mul_done,
    len_r == ($past(len_r) + 64'($past(ent_r.add_len))), "Length did not advance by the item.")

endmodule

// File: rtl/core/murmur3_128_stream_hash_unit.sv
// Streaming MurmurHash3 x64_128 with seed zero. Each item is a 16-byte chunk,
// little endian; the item with in_last_block set closes the message, carries
// 0 to 16 valid bytes in in_byte_count, and yields one result: the low 64 bits
// of the 128-bit hash. Other items give no result and count as 16 bytes.
// After a result the unit starts the next message from zero. Items enter a
// small queue, so the input stays open while the hash core works, until the
// queue fills. The core shares one 64-bit multiplier built from a 32x32
// array; a full chunk needs four products plus four lane steps, and the core
// takes a new item from the queue only when it is through with the last one.
// A last chunk adds a fold, two finalizers and the result step. A result
// waiting in the output register stalls the core only when the next result
// is ready.
module murmur3_128_stream_hash_unit #(
  parameter int QUEUE_DEPTH = mm3_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_block_low,
  input  logic [63:0] in_block_high,
  input  logic [4:0]  in_byte_count,
  input  logic        in_last_block,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_hash_value
);
  import mm3_pkg::*;

  logic   q_full;
  logic   q_push;
  entry_t q_entry;
  logic   q_empty;
  logic   q_pop;
  entry_t q_head;

  // Front: take items and clean up the chunk.
  mm3_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_block_low  (in_block_low),
    .in_block_high (in_block_high),
    .in_byte_count (in_byte_count),
    .in_last_block (in_last_block),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_entry       (q_entry)
  );

  // Queue between front and hash core.
  mm3_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .empty      (q_empty),
    .head       (q_head)
  );

  // Back: lane mixing, finalization and the result register.
  mm3_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .q_head         (q_head),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hash_value (out_hash_value)
  );

endmodule
